@@ src/kft_pkg.sv @@
// ============================================================================
// kft_pkg
// Shared types and constants for the k-mer frequency table.
// ============================================================================
package kft_pkg;

    localparam int KMER_W  = 32;
    localparam int COUNT_W = 24;
    localparam int ADD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE_MISSING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_CODE   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [KMER_W-1:0]  t_kmer;
    typedef logic [COUNT_W-1:0] t_count;

    // Ordering rule: a before b when count higher, ties by smaller k-mer
    function automatic logic goes_before(t_kmer ka, t_count ca, t_kmer kb, t_count cb);
        logic r;
        if (ca != cb) begin
            r = (ca > cb);
        end else begin
            r = (ka < kb);
        end
        return r;
    endfunction

endpackage

@@ src/kmer_frequency_table_sorted_top.sv @@
// ============================================================================
// kmer_frequency_table_sorted_top
// K-mer counting table with pruning and sorted read-out.
// ============================================================================
// An item scans the table one entry a cycle through a single RAM read port.
// On a final item the read-out is a selection sort over the same port: a run
// of n results needs n + 1 passes because the chosen entry is held until the
// next pass shows whether another one follows. The input is not ready while
// an item is being worked on.
module kmer_frequency_table_sorted_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int KMER_LEN    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [31:0]                 i_kmer_chars,
    input  logic [15:0]                 i_count_add,
    input  logic                        i_final_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_out_kmer,
    output logic [23:0]                 o_out_count,
    output logic                        o_entry_valid,
    output logic                        o_overflowed,
    output logic                        o_last_of_run
);
    import kft_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int NW     = $clog2(TABLE_DEPTH + 1);
    localparam int KCHARS = (KMER_LEN < 4) ? KMER_LEN : 4;
    localparam logic [KMER_W-1:0] KMASK =
        (KCHARS >= 4) ? '1 : KMER_W'((64'd1 << (8 * KCHARS)) - 64'd1);
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    // config registers
    logic [COUNT_W-1:0] r_lower_bound;
    logic               r_delete_missing;
    logic [7:0]         r_missing_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound    <= '0;
            r_delete_missing <= 1'b0;
            r_missing_code   <= 8'd95;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOWER_BOUND:    r_lower_bound    <= i_cfg_data;
                CFG_DELETE_MISSING: r_delete_missing <= i_cfg_data[0];
                CFG_MISSING_CODE:   r_missing_code   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control and payload registers
    logic [2:0]   r_state, n_state;
    logic [NW-1:0] r_used, n_used;
    logic         r_ovf, n_ovf;
    logic [NW-1:0] r_ptr, n_ptr;      // read address issued
    logic         r_rv, n_rv;         // read data valid next cycle
    logic [AW-1:0] r_raddr_q, n_raddr_q; // address of data now on rdata
    t_kmer        r_key, n_key;
    logic [ADD_W-1:0] r_add, n_add;
    logic         r_fin, n_fin;
    logic         r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    // selection sort: held entry (last chosen), best candidate of current pass
    t_kmer        r_lk, n_lk;
    t_count       r_lc, n_lc;
    logic         r_first, n_first;
    logic         r_bv, n_bv;
    t_kmer        r_bk, n_bk;
    t_count       r_bc, n_bc;
    logic         r_emitted, n_emitted;
    // output register
    logic         r_ov, n_ov;
    t_kmer        r_ok, n_ok;
    t_count       r_oc, n_oc;
    logic         r_oe, n_oe;
    logic         r_oo, n_oo;
    logic         r_ol, n_ol;

    // memories
    logic         w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_kmer        w_wk, w_rk;
    t_count       w_wc, w_rc;

    kft_ram #(.WIDTH(KMER_W), .DEPTH(TABLE_DEPTH)) u_kram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wk),
        .i_raddr(w_raddr), .o_rdata(w_rk));
    kft_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_DEPTH)) u_cram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wc),
        .i_raddr(w_raddr), .o_rdata(w_rc));

    assign w_raddr = r_ptr[AW-1:0];

    // missing-code test on the entry being read
    logic w_has_missing;
    always_comb begin
        w_has_missing = 1'b0;
        for (int i = 0; i < KCHARS; i++) begin
            if (w_rk[8*i +: 8] == r_missing_code) w_has_missing = 1'b1;
        end
    end

    logic w_keep, w_after_last, w_better;
    logic [COUNT_W:0] w_sum;
    assign w_keep = (w_rc > r_lower_bound) && !(r_delete_missing && w_has_missing);
    assign w_after_last = r_first || goes_before(r_lk, r_lc, w_rk, w_rc);
    assign w_better = !r_bv || goes_before(w_rk, w_rc, r_bk, r_bc);
    assign w_sum = {1'b0, w_rc} + {{(COUNT_W-ADD_W+1){1'b0}}, r_add};

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state; n_used = r_used; n_ovf = r_ovf; n_ptr = r_ptr;
        n_rv = 1'b0; n_raddr_q = r_ptr[AW-1:0];
        n_key = r_key; n_add = r_add; n_fin = r_fin;
        n_hit = r_hit; n_hit_idx = r_hit_idx;
        n_lk = r_lk; n_lc = r_lc; n_first = r_first;
        n_bv = r_bv; n_bk = r_bk; n_bc = r_bc; n_emitted = r_emitted;
        n_ov = r_ov; n_ok = r_ok; n_oc = r_oc; n_oe = r_oe; n_oo = r_oo; n_ol = r_ol;
        w_we = 1'b0; w_waddr = r_hit_idx; w_wk = r_key; w_wc = w_sum[COUNT_W-1:0];

        if (r_ov && i_ready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key = i_kmer_chars & KMASK;
                    n_add = i_count_add;
                    n_fin = i_final_item;
                    n_hit = 1'b0;
                    n_ptr = '0;
                    n_state = S_SCAN;
                end
            end
            // one entry per cycle: issue read, compare registered data
            S_SCAN: begin
                if (r_rv && !r_hit && (w_rk == r_key)) begin
                    n_hit = 1'b1;
                    n_hit_idx = r_raddr_q;
                    // point the read port back at the hit entry for the update
                    n_ptr = NW'(r_raddr_q);
                end
                if (r_ptr < r_used && !(r_hit || (r_rv && w_rk == r_key))) begin
                    n_ptr = r_ptr + 1'b1;
                    n_rv = 1'b1;
                end else if (!r_rv) begin
                    n_state = S_UPD;
                end
            end
            // accumulate, insert or drop
            S_UPD: begin
                if (r_hit) begin
                    w_we = 1'b1;
                    w_wc = w_sum[COUNT_W] ? COUNT_MAX : w_sum[COUNT_W-1:0];
                    n_state = r_fin ? S_SEL : S_IDLE;
                    n_ptr = '0;
                end else begin
                    n_ptr = '0;
                    if (r_used < DEPTH_N) begin
                        w_we = 1'b1;
                        w_waddr = r_used[AW-1:0];
                        w_wc = {{(COUNT_W-ADD_W){1'b0}}, r_add};
                        n_used = r_used + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = r_fin ? S_SEL : S_IDLE;
                end
                // on a hit, rdata now holds the hit entry's count
                n_first = 1'b1; n_bv = 1'b0; n_emitted = 1'b0;
            end
            // one pass: find best survivor after the last chosen one
            S_SEL: begin
                if (r_rv && w_keep && w_after_last && w_better) begin
                    n_bv = 1'b1; n_bk = w_rk; n_bc = w_rc;
                end
                if (r_ptr < r_used) begin
                    n_ptr = r_ptr + 1'b1;
                    n_rv = 1'b1;
                end else if (!r_rv) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_ready) begin
                    if (r_bv) begin
                        // another entry follows: push out the held one
                        if (r_emitted) begin
                            n_ov = 1'b1; n_ok = r_lk; n_oc = r_lc; n_oe = 1'b1;
                            n_oo = r_ovf; n_ol = 1'b0;
                        end
                        n_lk = r_bk; n_lc = r_bc; n_first = 1'b0;
                        n_emitted = 1'b1; n_bv = 1'b0; n_ptr = '0;
                        n_state = S_SEL;
                    end else begin
                        n_ov = 1'b1; n_ok = r_lk; n_oc = r_lc; n_oe = 1'b1;
                        n_oo = r_ovf; n_ol = 1'b1;
                        if (!r_emitted) begin
                            n_ok = '0; n_oc = '0; n_oe = 1'b0;
                        end
                        n_state = S_WAIT;
                        n_used = '0; n_ovf = 1'b0;
                    end
                end
            end
            S_WAIT: begin
                if (!r_ov || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The chosen entry is held in r_lk/r_lc and only pushed out once the
    // following pass shows whether more follow, so the final one can carry
    // last_of_run.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_ovf <= 1'b0; r_rv <= 1'b0;
            r_ov <= 1'b0; r_ptr <= '0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_ovf <= n_ovf; r_rv <= n_rv;
            r_ov <= n_ov; r_ptr <= n_ptr;
        end
        r_raddr_q <= n_raddr_q; r_key <= n_key; r_add <= n_add; r_fin <= n_fin;
        r_hit <= n_hit; r_hit_idx <= n_hit_idx; r_lk <= n_lk; r_lc <= n_lc;
        r_first <= n_first; r_bv <= n_bv; r_bk <= n_bk; r_bc <= n_bc;
        r_emitted <= n_emitted; r_ok <= n_ok; r_oc <= n_oc; r_oe <= n_oe;
        r_oo <= n_oo; r_ol <= n_ol;
    end

    assign o_valid       = r_ov;
    assign o_out_kmer    = r_ok;
    assign o_out_count   = r_oc;
    assign o_entry_valid = r_oe;
    assign o_overflowed  = r_oo;
    assign o_last_of_run = r_ol;

`ifndef SYNTHESIS
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_N) else $error("table count overrun");
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_entry_valid) |-> o_last_of_run) else $error("bad empty marker");
`endif
endmodule

@@ src/kft_ram.sv @@
// ============================================================================
// kft_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module kft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
